>>> rtl/hba_pkg.sv
// Shared types and constants of the handle bitmap allocator.
package hba_pkg;

    // Default sizes; WORD_BITS must be a power of two.
    localparam int HBA_MAX_HANDLES  = 1024;
    localparam int HBA_WORD_BITS    = 32;
    localparam int HBA_RESERVED_LOW = 3;

    localparam int HANDLE_IN_BITS  = 16;
    localparam int HANDLE_OUT_BITS = 10;
    localparam int STATUS_BITS     = 3;

    // Operation codes.
    localparam logic [1:0] OP_CLAIM = 2'd0;
    localparam logic [1:0] OP_ANY   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_TAKEN   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic [1:0]                op;
        logic [HANDLE_IN_BITS-1:0] handle_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic [HANDLE_OUT_BITS-1:0] handle_out;
    } t_rsp;

endpackage

>>> rtl/handle_bitmap_allocator.sv
// Top level of the handle bitmap allocator: request decode, bitmap scan and write-back.
//
// The block keeps one used/free bit per handle in a RAM of MAX_HANDLES/WORD_BITS words.
// After reset a clearing pass writes every word to zero, one word per cycle, while busy
// stays high. A request is taken when start is high and busy is low; its result appears
// on o_rsp for exactly one cycle with o_done high, and must be captured then.
// Out-of-range claims, ignored frees and undefined operations answer in the cycle after
// the request. Claim-specific and free do a read-modify-write of one word: the word is
// read while idle and written in S_MOD, the result is registered, and the next request
// can be taken in the cycle that carries the result. Claim-any reads the bitmap one word
// per cycle from word zero and answers with a grant from the first word that holds a
// free handle, or with full after the last word. The single RAM read port, one word per
// cycle, sets the claim-any time.
module handle_bitmap_allocator
    import hba_pkg::*;
#(
    parameter int MAX_HANDLES  = HBA_MAX_HANDLES,
    parameter int WORD_BITS    = HBA_WORD_BITS,
    parameter int RESERVED_LOW = HBA_RESERVED_LOW
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int NUM_WORDS = (MAX_HANDLES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MOD   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [1:0]                r_op, n_op;
    logic [HANDLE_IN_BITS-1:0] r_handle, n_handle;
    logic [AW-1:0]             r_word, n_word;
    logic [BW-1:0]             r_bit, n_bit;
    logic [AW-1:0]             r_scan, n_scan;
    logic [AW-1:0]             r_chk, n_chk;
    logic [AW-1:0]             r_clr, n_clr;
    logic                      r_done, n_done;
    t_rsp                      r_rsp, n_rsp;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_elig;
    logic [WORD_BITS-1:0] w_free;
    logic                 w_any;
    logic [BW-1:0]        w_idx;
    logic [31:0]          w_gnt;

    hba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Bits of the scanned word that claim-any may hand out.
    always_comb begin
        int pos;
        pos = 0;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos       = (int'(32'(r_chk)) << BW) + b;
            w_elig[b] = (pos >= RESERVED_LOW) && (pos < MAX_HANDLES);
        end
    end

    assign w_free = ~w_rdata & w_elig;
    assign w_any  = |w_free;

    always_comb begin
        w_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_idx = BW'(b);
            end
        end
    end

    assign w_gnt  = 32'({r_chk, w_idx});
    assign w_mask = WORD_BITS'(1) << r_bit;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_handle = r_handle;
        n_word   = r_word;
        n_bit    = r_bit;
        n_scan   = r_scan;
        n_chk    = r_chk;
        n_clr    = r_clr;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_waddr  = r_word;
        w_wdata  = w_rdata;
        w_raddr  = r_scan;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_raddr = AW'(i_req.handle_in >> BW);
                if (start) begin
                    n_op     = i_req.op;
                    n_handle = i_req.handle_in;
                    n_word   = AW'(i_req.handle_in >> BW);
                    n_bit    = i_req.handle_in[BW-1:0];
                    case (i_req.op)
                        OP_CLAIM: begin
                            if (32'(i_req.handle_in) >= MAX_HANDLES) begin
                                n_done = 1'b1;
                                n_rsp  = '{status: ST_RANGE, handle_out: '0};
                            end else begin
                                n_state = S_MOD;
                            end
                        end
                        OP_ANY: begin
                            w_raddr = '0;
                            n_scan  = AW'(1);
                            n_chk   = '0;
                            n_state = S_SCAN;
                        end
                        OP_FREE: begin
                            if (32'(i_req.handle_in) >= RESERVED_LOW &&
                                32'(i_req.handle_in) < MAX_HANDLES) begin
                                n_state = S_MOD;
                            end else begin
                                n_done = 1'b1;
                                n_rsp  = '{status: ST_IGNORED, handle_out: '0};
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_rsp  = '{status: ST_IGNORED, handle_out: '0};
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                w_waddr = r_word;
                if (r_op == OP_CLAIM) begin
                    if ((w_rdata & w_mask) != '0) begin
                        n_rsp = '{status: ST_TAKEN, handle_out: '0};
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata | w_mask;
                        n_rsp   = '{status: ST_OK,
                                    handle_out: r_handle[HANDLE_OUT_BITS-1:0]};
                    end
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata & ~w_mask;
                    n_rsp   = '{status: ST_OK, handle_out: '0};
                end
            end
            S_SCAN: begin
                // The word read for r_chk is on w_rdata while r_scan is being read.
                w_raddr = r_scan;
                n_scan  = r_scan + AW'(1);
                n_chk   = r_chk + AW'(1);
                if (w_any) begin
                    w_we    = 1'b1;
                    w_waddr = r_chk;
                    w_wdata = w_rdata | (WORD_BITS'(1) << w_idx);
                    n_done  = 1'b1;
                    n_rsp   = '{status: ST_OK, handle_out: w_gnt[HANDLE_OUT_BITS-1:0]};
                    n_state = S_IDLE;
                end else if (r_chk == AW'(NUM_WORDS - 1)) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: ST_FULL, handle_out: '0};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_op     <= n_op;
        r_handle <= n_handle;
        r_word   <= n_word;
        r_bit    <= n_bit;
        r_scan   <= n_scan;
        r_chk    <= n_chk;
        r_rsp    <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("bitmap written while idle");

    a_full_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == ST_FULL) |-> $past(r_state == S_SCAN))
        else $error("full reported outside a scan");

    a_grant_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_any) |=> (o_done && r_state == S_IDLE))
        else $error("scan did not finish on a free handle");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status == ST_OK || o_rsp.handle_out == '0))
        else $error("handle reported on a failed request");

    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |=> o_done)
        else $error("read-modify-write gave no result");
`endif

endmodule

>>> rtl/hba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hba_ram
    import hba_pkg::*;
#(
    parameter int WIDTH = HBA_WORD_BITS,
    parameter int DEPTH = HBA_MAX_HANDLES / HBA_WORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
